// ===== rtl/core/lfu_pkg.sv =====
// Package for the LFU cache with LRU tie-break.
// Holds the item and result types, the controller command and status structs and the codes.
// No dependencies.
package lfu_pkg;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam int CAP_REG_W = 5;
  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

  localparam logic REG_CAPACITY_IN_USE = 1'b0;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic latch;
    logic scan;
    logic decide;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_update;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/lfu_cache_with_lru_tiebreak_top.sv =====
// Top level of the LFU cache with LRU tie-break: APB register, controller and datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_dp.
//
// Usage: an item (get or put of a key) is accepted at a rising edge where start is high and
// busy is low. Each item gives exactly one result, shown on result for one cycle with done
// high; the receiver cannot stall it and must take it in that cycle.
// Each item first scans every entry of the entry memory, one entry per cycle, to find the
// key, the eviction victim and the lowest free slot. done is registered from the decision
// state that follows the scan, and the result is taken at the edge that ends the cycle in
// which done is high. A get that misses frees the block right after the decision. Every
// other item adds a second pass through the entry memory that rewrites recency ranks and
// use counts before busy falls. Both passes are paced by the single read port and single
// write port of the entry memory.
// The register capacity_in_use lies at byte address 0 and must be written only while busy
// is low; the block itself does not enforce this. Reset clears the valid bits at once, so
// the block can take an item right after reset; capacity_in_use returns to 16.
module lfu_cache_with_lru_tiebreak_top import lfu_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_W = IW + 1;

  logic [CAP_REG_W-1:0] capacity_in_use;
  ctrl_cmd_t            cmd;
  ctrl_sts_t            sts;
  logic [IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY_IN_USE) ? 32'(capacity_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY_IN_USE)) begin
      capacity_in_use <= pwdata[CAP_REG_W-1:0];
    end
  end

  lfu_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd),
    .idx   (idx)
  );

  lfu_dp #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .request         (request),
    .capacity_in_use (capacity_in_use),
    .cmd             (cmd),
    .idx             (idx),
    .sts             (sts),
    .done            (done),
    .result          (result)
  );

endmodule

// ===== rtl/core/lfu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lfu_ctrl.sv =====
// Controller of the LFU cache: sequences the scan pass, the decision and the update pass.
// Depends on lfu_pkg.
module lfu_ctrl import lfu_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int IDX_W = IW + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ctrl_sts_t         sts,
  output ctrl_cmd_t         cmd,
  output logic [IDX_W-1:0]  idx
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] idx_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_SCAN;
          idx_next   = '0;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LAST) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        idx_next   = '0;
        state_next = sts.need_update ? S_UPDATE : S_IDLE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        idx_next   = idx + 1'b1;
        if (idx == LAST) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== rtl/core/lfu_dp.sv =====
// Datapath of the LFU cache: entry memory, valid bits, scan results and result register.
// Depends on lfu_pkg and lfu_ram.
module lfu_dp import lfu_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16,
  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int IDX_W = IW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 request,
  input  logic [CAP_REG_W-1:0] capacity_in_use,
  input  ctrl_cmd_t            cmd,
  input  logic [IDX_W-1:0]     idx,
  output ctrl_sts_t            sts,
  output logic                 done,
  output rsp_t                 result
);

  localparam int RANK_W = IW;
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (OCC_W > CAP_REG_W) ? OCC_W : CAP_REG_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY);

  typedef struct packed {
    logic [31:0]            key;
    logic [31:0]            value;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [RANK_W-1:0]      rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  logic                   op;
  logic [31:0]            key;
  logic [31:0]            val;

  logic [CAPACITY-1:0]    valid;
  logic [OCC_W-1:0]       occ;

  logic                   proc_scan;
  logic                   proc_upd;
  logic [IW-1:0]          proc_idx;

  logic                   hit_found;
  logic [IW-1:0]          hit_idx;
  logic [RANK_W-1:0]      hit_rank;
  logic [31:0]            hit_val;
  logic                   vic_found;
  logic [IW-1:0]          vic_idx;
  logic [COUNT_WIDTH-1:0] vic_cnt;
  logic [RANK_W-1:0]      vic_rank;
  logic [31:0]            vic_key;
  logic                   free_found;
  logic [IW-1:0]          free_idx;

  logic [IW-1:0]          slot;
  logic [RANK_W-1:0]      pivot;
  logic                   bump_all;
  logic                   is_insert;

  logic                   rd_en;
  logic [ENTRY_W-1:0]     rd_word;
  entry_t                 rd;
  entry_t                 wr;

  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic                   rd_valid;
  rsp_t                   rsp_next;

  assign rd       = entry_t'(rd_word);
  assign rd_en    = (cmd.scan || cmd.update) && (idx != LAST);
  assign rd_valid = valid[proc_idx];

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (proc_upd),
    .waddr (proc_idx),
    .wdata (ENTRY_W'(wr)),
    .re    (rd_en),
    .raddr (idx[IW-1:0]),
    .rdata (rd_word)
  );

  assign cap_ext = CMP_W'(capacity_in_use);

  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      eff_cap = CMP_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full            = (CMP_W'(occ) >= eff_cap);
  assign sts.need_update = hit_found || (op == OP_PUT);

  always_comb begin
    rsp_next = '0;
    if (hit_found) begin
      rsp_next.hit = 1'b1;
      if (op == OP_GET) begin
        rsp_next.read_value = hit_val;
      end
    end else if ((op == OP_PUT) && full) begin
      rsp_next.evicted     = 1'b1;
      rsp_next.evicted_key = vic_key;
    end
  end

  always_comb begin
    wr = rd;
    if (proc_idx == slot) begin
      if (is_insert) begin
        wr.key   = key;
        wr.value = val;
        wr.cnt   = COUNT_WIDTH'(1);
        wr.rank  = '0;
      end else begin
        if (op == OP_PUT) begin
          wr.value = val;
        end
        if (rd.cnt != '1) begin
          wr.cnt = rd.cnt + 1'b1;
        end
        wr.rank = '0;
      end
    end else if (rd_valid && (bump_all || (rd.rank < pivot))) begin
      wr.rank = rd.rank + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= idx[IW-1:0];
    if (cmd.latch) begin
      op  <= request.opcode;
      key <= request.lookup_key;
      val <= request.store_value;
    end
    if (proc_scan) begin
      if (rd_valid) begin
        if (!hit_found && (rd.key == key)) begin
          hit_idx  <= proc_idx;
          hit_rank <= rd.rank;
          hit_val  <= rd.value;
        end
        if (!vic_found || (rd.cnt < vic_cnt) ||
            ((rd.cnt == vic_cnt) && (rd.rank > vic_rank))) begin
          vic_idx  <= proc_idx;
          vic_cnt  <= rd.cnt;
          vic_rank <= rd.rank;
          vic_key  <= rd.key;
        end
      end else if (!free_found) begin
        free_idx <= proc_idx;
      end
    end
    if (cmd.decide) begin
      result <= rsp_next;
      if (hit_found) begin
        slot      <= hit_idx;
        pivot     <= hit_rank;
        bump_all  <= 1'b0;
        is_insert <= 1'b0;
      end else if (op == OP_PUT) begin
        is_insert <= 1'b1;
        if (full) begin
          slot     <= vic_idx;
          pivot    <= vic_rank;
          bump_all <= 1'b0;
        end else begin
          slot     <= free_idx;
          pivot    <= '0;
          bump_all <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      occ        <= '0;
      proc_scan  <= 1'b0;
      proc_upd   <= 1'b0;
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      proc_scan <= cmd.scan && (idx != LAST);
      proc_upd  <= cmd.update && (idx != LAST);
      done      <= cmd.decide;
      if (cmd.latch) begin
        hit_found  <= 1'b0;
        vic_found  <= 1'b0;
        free_found <= 1'b0;
      end
      if (proc_scan) begin
        if (rd_valid) begin
          if (rd.key == key) begin
            hit_found <= 1'b1;
          end
          vic_found <= 1'b1;
        end else begin
          free_found <= 1'b1;
        end
      end
      if (cmd.decide && !hit_found && (op == OP_PUT) && !full) begin
        valid[free_idx] <= 1'b1;
        occ             <= occ + 1'b1;
      end
    end
  end

endmodule

// ===== test/tb_lfu_cache_with_lru_tiebreak_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lfu_cache_with_lru_tiebreak_top: a queue-fed driver, a predictor
// of the cache contents and a monitor that checks every result against it.
// Depends on lfu_pkg and the top level of the cache.
module tb_lfu_cache_with_lru_tiebreak_top;
  import lfu_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int COUNT_W     = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] CAP_ADDR    = 3'(4 * REG_CAPACITY_IN_USE);
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  typedef enum logic [1:0] {ACT_OP, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t   kind;
    req_t        req;
    int          gap;
    logic [2:0]  addr;
    logic [31:0] data;
  } cache_action_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic        busy;
  req_t        request = '0;
  logic        done;
  rsp_t        result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  cache_action_t action_q[$];
  rsp_t          expected_rsp_q[$];
  int            err_cnt   = 0;
  int            cycle_cnt = 0;
  int            gap_left  = 0;

  logic                   m_valid [CAPACITY];
  logic [31:0]            m_key   [CAPACITY];
  logic [31:0]            m_value [CAPACITY];
  logic [COUNT_W-1:0]     m_count [CAPACITY];
  int                     m_rank  [CAPACITY];
  logic [CAP_REG_W-1:0]   m_capacity;

  logic          taken;
  logic          start_n;
  logic          cache_idle;
  cache_action_t nxt;
  rsp_t          exp_rsp;

  lfu_cache_with_lru_tiebreak_top #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  function automatic rsp_t lfu_predict(req_t rq);
    rsp_t rs;
    int   idx;
    int   n;
    int   slot;
    int   vic;
    int   r;
    int   eff;
    rs   = '0;
    idx  = -1;
    slot = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (idx < 0 && m_valid[i] && m_key[i] == rq.lookup_key) idx = i;
    if (idx >= 0) begin
      rs.hit = 1'b1;
      if (rq.opcode == OP_GET) rs.read_value = m_value[idx];
      else m_value[idx] = rq.store_value;
      r = m_rank[idx];
      for (int i = 0; i < CAPACITY; i++)
        if (m_valid[i] && m_rank[i] < r) m_rank[i]++;
      m_rank[idx] = 0;
      if (m_count[idx] != '1) m_count[idx]++;
    end else if (rq.opcode == OP_PUT) begin
      n = 0;
      for (int i = 0; i < CAPACITY; i++) if (m_valid[i]) n++;
      eff = (m_capacity == 0) ? 1 : (m_capacity > CAPACITY) ? CAPACITY : int'(m_capacity);
      if (n >= eff) begin
        vic = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (m_valid[i] && (vic < 0 || m_count[i] < m_count[vic] ||
              (m_count[i] == m_count[vic] && m_rank[i] > m_rank[vic])))
            vic = i;
        end
        if (vic >= 0) begin
          r              = m_rank[vic];
          rs.evicted     = 1'b1;
          rs.evicted_key = m_key[vic];
          m_valid[vic]   = 1'b0;
          for (int i = 0; i < CAPACITY; i++)
            if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
          slot = vic;
        end
      end
      if (slot < 0)
        for (int i = 0; i < CAPACITY; i++)
          if (slot < 0 && !m_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < CAPACITY; i++) if (m_valid[i]) m_rank[i]++;
        m_valid[slot] = 1'b1;
        m_key[slot]   = rq.lookup_key;
        m_value[slot] = rq.store_value;
        m_count[slot] = COUNT_W'(1);
        m_rank[slot]  = 0;
      end
    end
    return rs;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  task automatic add_op(logic op, logic [31:0] key, logic [31:0] val, bit quiet);
    cache_action_t a;
    a.kind              = ACT_OP;
    a.req.opcode        = op;
    a.req.lookup_key    = key;
    a.req.store_value   = val;
    a.gap               = pick_gap(quiet);
    a.addr              = '0;
    a.data              = '0;
    action_q.insert(action_q.size(), a);
  endtask

  task automatic add_cfg(logic [2:0] addr, logic [31:0] data);
    cache_action_t a;
    a.kind = ACT_DRAIN;
    a.req  = '0;
    a.gap  = 0;
    a.addr = addr;
    a.data = data;
    action_q.insert(action_q.size(), a);
    a.kind = ACT_CFG;
    action_q.insert(action_q.size(), a);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      err_cnt++;
      if (err_cnt <= 50)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
    end
  endtask

  // Driver: issues items, register writes and pauses in queue order.
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      gap_left <= 0;
    end else begin
      taken   = start && !busy;
      start_n = start && !taken;
      if (taken) expected_rsp_q.insert(expected_rsp_q.size(), lfu_predict(request));
      cache_idle = (expected_rsp_q.size() == 0) && !busy && !start;
      if (psel && penable) begin
        if (pwrite && pready && paddr == CAP_ADDR) m_capacity = pwdata[CAP_REG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
      end else if (psel) begin
        penable <= 1'b1;
      end else if (!start_n) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (action_q.size() > 0) begin
          nxt = action_q[0];
          unique case (nxt.kind)
            ACT_OP: begin
              request  <= nxt.req;
              start_n  = 1'b1;
              gap_left <= nxt.gap;
              void'(action_q.pop_front());
            end
            ACT_CFG: begin
              if (cache_idle) begin
                psel   <= 1'b1;
                pwrite <= 1'b1;
                paddr  <= nxt.addr;
                pwdata <= nxt.data;
                void'(action_q.pop_front());
              end
            end
            default: begin
              if (cache_idle) void'(action_q.pop_front());
            end
          endcase
        end
      end
      start <= start_n;
    end
  end

  // Monitor: every result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 50)
          $display("%0t: unexpected result, expected none actual %h", $time, result);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        check_field("hit", 32'(exp_rsp.hit), 32'(result.hit));
        check_field("read_value", exp_rsp.read_value, result.read_value);
        check_field("evicted", 32'(exp_rsp.evicted), 32'(result.evicted));
        check_field("evicted_key", exp_rsp.evicted_key, result.evicted_key);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          caps [8];
    logic [31:0] pool [24];
    int          psz;
    int          eff;
    int          capw;
    int          r;
    logic [31:0] key;
    bit          quiet;

    caps = '{16, 3, 0, 31, 1, 8, 2, 16};
    m_capacity = CAP_RESET;
    for (int i = 0; i < CAPACITY; i++) begin
      m_valid[i] = 1'b0;
      m_key[i]   = '0;
      m_value[i] = '0;
      m_count[i] = '0;
      m_rank[i]  = 0;
    end

    add_op(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    add_op(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_op(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_op(OP_PUT, 32'h0000_0000, 32'h0000_0000, 0);
    add_op(OP_PUT, 32'h0000_0001, 32'h1234_5678, 0);
    add_op(OP_GET, 32'h8000_0000, 32'h5555_5555, 0);
    add_op(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    add_op(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 0);
    add_op(OP_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 0);
    add_op(OP_GET, 32'h0000_0001, 32'h0000_0000, 0);
    add_op(OP_GET, 32'h0000_0001, 32'h0000_0000, 0);
    add_cfg(CAP_ADDR, 32'h0000_0000);
    add_op(OP_PUT, 32'h0000_0002, 32'hDEAD_BEEF, 0);
    add_op(OP_PUT, 32'h0000_0003, 32'h0BAD_F00D, 0);
    add_op(OP_GET, 32'h0000_0002, 32'h0000_0000, 0);
    add_cfg(UNUSED_ADDR, 32'h0000_0001);
    add_op(OP_PUT, 32'h0000_0004, 32'h0000_0044, 0);
    add_cfg(CAP_ADDR, 32'hFFFF_FFFF);
    add_op(OP_PUT, 32'h0000_0005, 32'h0000_0055, 0);
    add_op(OP_PUT, 32'h0000_0006, 32'h0000_0066, 0);
    add_op(OP_GET, 32'h0000_0004, 32'h0000_0000, 0);

    for (int ph = 0; ph < 8; ph++) begin
      capw = (ph == 5) ? $urandom_range(1, 16) : caps[ph];
      add_cfg(CAP_ADDR, ($urandom & 32'hFFFF_FFE0) | 32'(capw));
      if (ph == 2) add_cfg(UNUSED_ADDR, $urandom);
      eff = (capw == 0) ? 1 : (capw > CAPACITY) ? CAPACITY : capw;
      psz = eff + $urandom_range(1, 5);
      if (psz > 24) psz = 24;
      for (int i = 0; i < psz; i++)
        pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 40)) : $urandom;
      quiet = (ph == 6);
      for (int k = 0; k < 135; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) key = $urandom;
        else if (r < 40) key = pool[$urandom_range(0, 1)];
        else key = pool[$urandom_range(0, psz - 1)];
        add_op(logic'($urandom_range(0, 1)), key, $urandom, quiet);
        if (k == 70 && (ph % 2) == 1) add_cfg(CAP_ADDR, 32'(capw));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (action_q.size() != 0 || start || expected_rsp_q.size() != 0 || busy)
      @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lfu_pkg.sv
rtl/core/lfu_ram.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dp.sv
rtl/core/lfu_cache_with_lru_tiebreak_top.sv
test/tb_lfu_cache_with_lru_tiebreak_top.sv
